// ----- rtl/core/q8dp_pkg.sv -----
`timescale 1ns / 1ps
// Shared package of the block-quantised int8 dot product.
// Holds widths, fp32 constants, the sequencer and unit state types and the request struct.
package q8dp_pkg;

  localparam int BLOCK_LEN_DEF = 32;
  localparam int VAL_W         = 8;
  localparam int FP_W          = 32;
  localparam int EXP_W         = 11;
  localparam int MANT_W        = 50;
  localparam logic [FP_W-1:0] DEFAULT_NAN = 32'hFFC00000;
  localparam logic [FP_W-1:0] QUIET_BIT   = 32'h00400000;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_I2F
  } fop_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCALE,
    SEQ_CONV,
    SEQ_TERM,
    SEQ_ACC,
    SEQ_EMIT
  } seq_t;

  typedef enum logic {
    FST_IDLE,
    FST_NORM
  } fst_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fpu_req_t;

endpackage

// ----- rtl/core/q8dp_fpu.sv -----
`timescale 1ns / 1ps
// Shared fp32 unit: multiply, add and integer conversion with round-to-nearest-even.
// Normalisation runs one bit a cycle; depends on q8dp_pkg.
module q8dp_fpu #(
  parameter int SUM_W = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  q8dp_pkg::fpu_req_t             req,
  input  logic [q8dp_pkg::FP_W-1:0]      opa,
  input  logic [q8dp_pkg::FP_W-1:0]      opb,
  input  logic signed [SUM_W-1:0]        int_in,
  output logic                           done,
  output logic [q8dp_pkg::FP_W-1:0]      result
);

  localparam int MW = q8dp_pkg::MANT_W;
  localparam int EW = q8dp_pkg::EXP_W;

  q8dp_pkg::fst_t          fst_r, fst_nxt;
  logic                    s_r, s_nxt;
  logic signed [EW-1:0]    e_r, e_nxt;
  logic [MW-1:0]           m_r, m_nxt;
  logic                    done_r, done_nxt;
  logic [q8dp_pkg::FP_W-1:0] res_r, res_nxt;

  logic [7:0]   ea_f, eb_f, eu_a, eu_b, eu_big, eu_sm, d;
  logic [23:0]  sig_a, sig_b, sig_big, sig_sm;
  logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big, sub, s_big;
  logic [47:0]  prod;
  logic [MW-1:0] m_big, m_sm_full, m_sm_shift, m_sm, m_add;
  logic [SUM_W-1:0] mag;
  logic [q8dp_pkg::FP_W-1:0] nan_prop;
  logic         fin;
  logic [23:0]  mant24;
  logic [24:0]  mant25;
  logic         rnd;
  logic signed [EW-1:0] ef;
  logic [22:0]  frac;
  logic [q8dp_pkg::FP_W-1:0] packed_res;

  always_comb begin
    ea_f   = opa[30:23];
    eb_f   = opb[30:23];
    sig_a  = {|ea_f, opa[22:0]};
    sig_b  = {|eb_f, opb[22:0]};
    eu_a   = (ea_f == 8'd0) ? 8'd1 : ea_f;
    eu_b   = (eb_f == 8'd0) ? 8'd1 : eb_f;
    a_nan  = (&ea_f) && (|opa[22:0]);
    b_nan  = (&eb_f) && (|opb[22:0]);
    a_inf  = (&ea_f) && !(|opa[22:0]);
    b_inf  = (&eb_f) && !(|opb[22:0]);
    a_zero = !(|opa[30:0]);
    b_zero = !(|opb[30:0]);
    nan_prop = a_nan ? (opa | q8dp_pkg::QUIET_BIT) : (opb | q8dp_pkg::QUIET_BIT);
    prod   = sig_a * sig_b;
    a_big  = (eu_a > eu_b) || ((eu_a == eu_b) && (sig_a >= sig_b));
    eu_big = a_big ? eu_a : eu_b;
    eu_sm  = a_big ? eu_b : eu_a;
    sig_big = a_big ? sig_a : sig_b;
    sig_sm  = a_big ? sig_b : sig_a;
    s_big  = a_big ? opa[31] : opb[31];
    sub    = opa[31] ^ opb[31];
    d      = eu_big - eu_sm;
    m_big  = {1'b0, sig_big, 25'd0};
    m_sm_full = {1'b0, sig_sm, 25'd0};
    m_sm_shift = m_sm_full >> d;
    if (d >= 8'd50) begin
      m_sm = {{(MW-1){1'b0}}, |sig_sm};
    end else begin
      m_sm = m_sm_shift | {{(MW-1){1'b0}}, ((m_sm_shift << d) != m_sm_full)};
    end
    m_add = sub ? (m_big - m_sm) : (m_big + m_sm);
    mag   = int_in[SUM_W-1] ? SUM_W'(-int_in) : SUM_W'(int_in);

    fin = (m_r == '0) ||
          (!m_r[MW-1] && (e_r >= 11'sd1) && (m_r[MW-2] || (e_r == 11'sd1)));
    mant24 = m_r[48:25];
    rnd    = m_r[24] && ((|m_r[23:0]) || mant24[0]);
    mant25 = {1'b0, mant24} + 25'(rnd);
    if (mant25[24]) begin
      ef   = e_r + 11'sd1;
      frac = 23'd0;
    end else begin
      ef   = mant25[23] ? e_r : '0;
      frac = mant25[22:0];
    end
    if (ef >= 11'sd255) begin
      packed_res = {s_r, 8'hFF, 23'd0};
    end else begin
      packed_res = {s_r, ef[7:0], frac};
    end

    fst_nxt  = fst_r;
    s_nxt    = s_r;
    e_nxt    = e_r;
    m_nxt    = m_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    case (fst_r)
      q8dp_pkg::FST_IDLE: begin
        if (req.start) begin
          case (req.op)
            q8dp_pkg::FOP_MUL: begin
              if (a_nan || b_nan) begin
                res_nxt  = nan_prop;
                done_nxt = 1'b1;
              end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                res_nxt  = q8dp_pkg::DEFAULT_NAN;
                done_nxt = 1'b1;
              end else if (a_inf || b_inf) begin
                res_nxt  = {opa[31] ^ opb[31], 8'hFF, 23'd0};
                done_nxt = 1'b1;
              end else begin
                s_nxt   = opa[31] ^ opb[31];
                e_nxt   = EW'($signed({3'b0, eu_a})) + EW'($signed({3'b0, eu_b})) - 11'sd127;
                m_nxt   = {prod, 2'b0};
                fst_nxt = q8dp_pkg::FST_NORM;
              end
            end
            q8dp_pkg::FOP_ADD: begin
              if (a_nan || b_nan) begin
                res_nxt  = nan_prop;
                done_nxt = 1'b1;
              end else if (a_inf && b_inf && sub) begin
                res_nxt  = q8dp_pkg::DEFAULT_NAN;
                done_nxt = 1'b1;
              end else if (a_inf) begin
                res_nxt  = opa;
                done_nxt = 1'b1;
              end else if (b_inf) begin
                res_nxt  = opb;
                done_nxt = 1'b1;
              end else begin
                s_nxt   = (sub && (m_add == '0)) ? 1'b0 : s_big;
                e_nxt   = EW'($signed({3'b0, eu_big}));
                m_nxt   = m_add;
                fst_nxt = q8dp_pkg::FST_NORM;
              end
            end
            q8dp_pkg::FOP_I2F: begin
              s_nxt   = int_in[SUM_W-1];
              e_nxt   = 11'sd175;
              m_nxt   = MW'(mag);
              fst_nxt = q8dp_pkg::FST_NORM;
            end
            default: begin
              res_nxt  = q8dp_pkg::DEFAULT_NAN;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      q8dp_pkg::FST_NORM: begin
        if (fin) begin
          res_nxt  = packed_res;
          done_nxt = 1'b1;
          fst_nxt  = q8dp_pkg::FST_IDLE;
        end else if (m_r[MW-1]) begin
          m_nxt = (m_r >> 1) | {{(MW-1){1'b0}}, m_r[0]};
          e_nxt = e_r + 11'sd1;
        end else if (e_r < -11'sd60) begin
          m_nxt = {{(MW-1){1'b0}}, |m_r};
          e_nxt = 11'sd1;
        end else if (e_r < 11'sd1) begin
          m_nxt = (m_r >> 1) | {{(MW-1){1'b0}}, m_r[0]};
          e_nxt = e_r + 11'sd1;
        end else begin
          m_nxt = m_r << 1;
          e_nxt = e_r - 11'sd1;
        end
      end
      default: begin
        fst_nxt = q8dp_pkg::FST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= q8dp_pkg::FST_IDLE;
      done_r <= 1'b0;
    end else begin
      fst_r  <= fst_nxt;
      done_r <= done_nxt;
    end
    s_r   <= s_nxt;
    e_r   <= e_nxt;
    m_r   <= m_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ----- rtl/core/block_quantized_int8_dot_product.sv -----
`timescale 1ns / 1ps
// Top level of the block-quantised int8 dot product: integer block sum and fp32 sequencer.
// Depends on q8dp_pkg and q8dp_fpu.
//
//   channel   ports                                              direction
//   input     in_valid in_stall in_act_value in_wgt_value ...    in
//   result    out_valid out_stall out_dot_result                 out
//
// A beat that does not close a block is taken without stalling input.
// A beat that closes a block stalls input for four passes through the fp32 unit.
// A pass finishes without normalisation for a NaN or infinite operand, otherwise it
// normalises one bit at a time, so the length of the stall depends on the data.
// A final beat then loads the result register from the emit state.
// After reset the accumulator is +0.0 and the block sum and position are zero.
// A stalled result holds its output register; the sequencer waits in its emit state.
module block_quantized_int8_dot_product #(
  parameter int BLOCK_LEN = q8dp_pkg::BLOCK_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [7:0]             in_act_value,
  input  logic signed [7:0]             in_wgt_value,
  input  logic [31:0]                   in_act_scale,
  input  logic [31:0]                   in_wgt_scale,
  input  logic                          in_first_elem,
  input  logic                          in_last_elem,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_dot_result
);

  localparam int SUM_W = 16 + $clog2(BLOCK_LEN);
  localparam int POS_W = $clog2(BLOCK_LEN + 1);

  q8dp_pkg::seq_t          st_r, st_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, hold_r, hold_nxt, base_sum, new_sum;
  logic [POS_W-1:0]        pos_r, pos_nxt, base_pos, new_pos;
  logic [31:0]             acc_r, acc_nxt, sa_r, sa_nxt, sw_r, sw_nxt;
  logic [31:0]             scale_r, scale_nxt, sumf_r, sumf_nxt;
  logic                    last_r, last_nxt, go_r, go_nxt;
  logic                    ov_r, ov_nxt;
  logic [31:0]             od_r, od_nxt;
  logic signed [15:0]      prod;
  logic                    accept, close;
  q8dp_pkg::fpu_req_t      req;
  logic [31:0]             fa, fb, fres;
  logic                    fdone;

  q8dp_fpu #(.SUM_W(SUM_W)) u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (fa),
    .opb    (fb),
    .int_in (hold_r),
    .done   (fdone),
    .result (fres)
  );

  always_comb begin
    accept   = in_valid && (st_r == q8dp_pkg::SEQ_IDLE);
    prod     = in_act_value * in_wgt_value;
    base_sum = in_first_elem ? '0 : sum_r;
    base_pos = in_first_elem ? '0 : pos_r;
    new_sum  = base_sum + SUM_W'(prod);
    new_pos  = base_pos + POS_W'(1);
    close    = (new_pos >= POS_W'(BLOCK_LEN)) || in_last_elem;

    req.start = go_r;
    req.op    = q8dp_pkg::FOP_MUL;
    fa        = sa_r;
    fb        = sw_r;
    case (st_r)
      q8dp_pkg::SEQ_CONV: begin
        req.op = q8dp_pkg::FOP_I2F;
      end
      q8dp_pkg::SEQ_TERM: begin
        fa = sumf_r;
        fb = scale_r;
      end
      q8dp_pkg::SEQ_ACC: begin
        req.op = q8dp_pkg::FOP_ADD;
        fa     = acc_r;
        fb     = fres;
      end
      default: begin
      end
    endcase

    st_nxt    = st_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    hold_nxt  = hold_r;
    acc_nxt   = acc_r;
    sa_nxt    = sa_r;
    sw_nxt    = sw_r;
    scale_nxt = scale_r;
    sumf_nxt  = sumf_r;
    last_nxt  = last_r;
    go_nxt    = 1'b0;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    case (st_r)
      q8dp_pkg::SEQ_IDLE: begin
        if (accept) begin
          if (in_first_elem) begin
            acc_nxt = '0;
          end
          if (close) begin
            sum_nxt  = '0;
            pos_nxt  = '0;
            hold_nxt = new_sum;
            sa_nxt   = in_act_scale;
            sw_nxt   = in_wgt_scale;
            last_nxt = in_last_elem;
            go_nxt   = 1'b1;
            st_nxt   = q8dp_pkg::SEQ_SCALE;
          end else begin
            sum_nxt = new_sum;
            pos_nxt = new_pos;
          end
        end
      end
      q8dp_pkg::SEQ_SCALE: begin
        if (fdone) begin
          scale_nxt = fres;
          go_nxt    = 1'b1;
          st_nxt    = q8dp_pkg::SEQ_CONV;
        end
      end
      q8dp_pkg::SEQ_CONV: begin
        if (fdone) begin
          sumf_nxt = fres;
          go_nxt   = 1'b1;
          st_nxt   = q8dp_pkg::SEQ_TERM;
        end
      end
      q8dp_pkg::SEQ_TERM: begin
        if (fdone) begin
          go_nxt = 1'b1;
          st_nxt = q8dp_pkg::SEQ_ACC;
        end
      end
      q8dp_pkg::SEQ_ACC: begin
        if (fdone) begin
          acc_nxt = fres;
          st_nxt  = last_r ? q8dp_pkg::SEQ_EMIT : q8dp_pkg::SEQ_IDLE;
        end
      end
      q8dp_pkg::SEQ_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt  = 1'b1;
          od_nxt  = acc_r;
          acc_nxt = '0;
          st_nxt  = q8dp_pkg::SEQ_IDLE;
        end
      end
      default: begin
        st_nxt = q8dp_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= q8dp_pkg::SEQ_IDLE;
      sum_r <= '0;
      pos_r <= '0;
      acc_r <= '0;
      go_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      go_r  <= go_nxt;
      ov_r  <= ov_nxt;
    end
    hold_r  <= hold_nxt;
    sa_r    <= sa_nxt;
    sw_r    <= sw_nxt;
    scale_r <= scale_nxt;
    sumf_r  <= sumf_nxt;
    last_r  <= last_nxt;
    od_r    <= od_nxt;
  end

  assign in_stall       = (st_r != q8dp_pkg::SEQ_IDLE);
  assign out_valid      = ov_r;
  assign out_dot_result = od_r;

endmodule

// ----- rtl/core/q8dp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the block-quantised int8 dot product, bound to the top level.
// Depends only on the top level's ports.
module q8dp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_elem,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_dot_result
);

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !in_stall && !out_valid)
    else $error("Block not idle after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dot_result))
    else $error("Stalled result beat changed.");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_elem |=> in_stall && !$rose(out_valid))
    else $error("Final beat did not start the scaling sequence.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result beat appeared without a closing sequence.");

endmodule

bind block_quantized_int8_dot_product q8dp_checker u_q8dp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_elem   (in_last_elem),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_dot_result (out_dot_result)
);
